FILE: rtl/tlca_pkg.sv
// Shared types and constants for the binary-lifting LCA engine.
// Item and result structs, controller states, command and status bundles.
// No dependencies.
package tlca_pkg;

   localparam int NODE_W         = 10;
   localparam int DEPTH_W        = 10;
   localparam int KIND_W         = 2;
   localparam int DEF_MAX_NODES  = 1024;
   localparam int DEF_LOG_LEVELS = 10;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [NODE_W-1:0]  node;
      logic [NODE_W-1:0]  parent;
      logic [DEPTH_W-1:0] depth;
      logic [NODE_W-1:0]  other_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic              done_res;
      logic              error;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_BINIT,
      ST_BRD0,
      ST_BRD1,
      ST_BWR,
      ST_QDA,
      ST_QDB,
      ST_QDIFF,
      ST_LIFT,
      ST_LIFT_UP,
      ST_MEET,
      ST_JUMP_RD,
      ST_JUMP_UP,
      ST_FIN_RD,
      ST_FIN_UP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic item_load;
      logic res_clear;
      logic res_err;
      logic res_done;
      logic tbl_wr;
      logic bld_init;
      logic bld_rd0;
      logic bld_rd1;
      logic bld_wr;
      logic rd_depth_a;
      logic rd_depth_b;
      logic q_diff;
      logic lift_rd;
      logic lift_up;
      logic meet_res;
      logic jump_init;
      logic jump_rd;
      logic jump_up;
      logic fin_rd;
      logic fin_up;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              load_ok;
      logic              query_ok;
      logic              bld_last;
      logic              diff_zero;
      logic              ab_equal;
      logic              jump_last;
      logic              rsp_free;
   } sts_type;

endpackage

FILE: rtl/tlca_ctrl.sv
// Sequencer for the LCA engine: load, table build and query walks.
// Drives tlca_dpath through cmd_type and reads back sts_type.
// Depends on tlca_pkg.
module tlca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlca_pkg::sts_type sts,
   output tlca_pkg::cmd_type cmd
);
   import tlca_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (sts.kind)
               KIND_LOAD:  state_in = sts.load_ok ? ST_LOAD : ST_DONE;
               KIND_BUILD: state_in = ST_BINIT;
               KIND_QUERY: state_in = sts.query_ok ? ST_QDA : ST_DONE;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_LOAD:    state_in = ST_DONE;
         ST_BINIT:   state_in = ST_BRD0;
         ST_BRD0:    state_in = ST_BRD1;
         ST_BRD1:    state_in = ST_BWR;
         ST_BWR:     state_in = sts.bld_last ? ST_DONE : ST_BRD0;
         ST_QDA:     state_in = ST_QDB;
         ST_QDB:     state_in = ST_QDIFF;
         ST_QDIFF:   state_in = ST_LIFT;
         ST_LIFT:    state_in = sts.diff_zero ? ST_MEET : ST_LIFT_UP;
         ST_LIFT_UP: state_in = ST_LIFT;
         ST_MEET:    state_in = sts.ab_equal ? ST_DONE : ST_JUMP_RD;
         ST_JUMP_RD: state_in = ST_JUMP_UP;
         ST_JUMP_UP: state_in = sts.jump_last ? ST_FIN_RD : ST_JUMP_RD;
         ST_FIN_RD:  state_in = ST_FIN_UP;
         ST_FIN_UP:  state_in = ST_DONE;
         ST_DONE: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.item_load = req_valid;
         end
         ST_DECODE: begin
            cmd.res_clear = 1'b1;
            case (sts.kind)
               KIND_LOAD:  cmd.res_err = !sts.load_ok;
               KIND_QUERY: cmd.res_err = !sts.query_ok;
               default:    cmd.res_err = 1'b0;
            endcase
         end
         ST_LOAD: begin
            cmd.tbl_wr   = 1'b1;
            cmd.res_done = 1'b1;
         end
         ST_BINIT:   cmd.bld_init = 1'b1;
         ST_BRD0:    cmd.bld_rd0 = 1'b1;
         ST_BRD1:    cmd.bld_rd1 = 1'b1;
         ST_BWR: begin
            cmd.bld_wr   = 1'b1;
            cmd.res_done = sts.bld_last;
         end
         ST_QDA:     cmd.rd_depth_a = 1'b1;
         ST_QDB:     cmd.rd_depth_b = 1'b1;
         ST_QDIFF:   cmd.q_diff = 1'b1;
         ST_LIFT:    cmd.lift_rd = !sts.diff_zero;
         ST_LIFT_UP: cmd.lift_up = 1'b1;
         ST_MEET: begin
            cmd.meet_res  = sts.ab_equal;
            cmd.jump_init = !sts.ab_equal;
         end
         ST_JUMP_RD: cmd.jump_rd = 1'b1;
         ST_JUMP_UP: cmd.jump_up = 1'b1;
         ST_FIN_RD:  cmd.fin_rd = 1'b1;
         ST_FIN_UP:  cmd.fin_up = 1'b1;
         ST_DONE:    cmd.rsp_load = sts.rsp_free;
         default:    cmd = '0;
      endcase
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DECODE)
      else $error("accepted item did not move to decode");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !sts.rsp_free |=> state_ff == ST_DONE)
      else $error("left done while the result slot was full");

   a_res_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.res_err, cmd.res_done, cmd.meet_res, cmd.fin_up}))
      else $error("conflicting result updates");

endmodule

FILE: rtl/tlca_dpath.sv
// Datapath of the LCA engine: item and config registers, ancestor and depth
// memories, lifting and jump registers, result and output registers.
// Depends on tlca_pkg; sequenced by tlca_ctrl.
module tlca_dpath #(
   parameter int MAX_NODES  = tlca_pkg::DEF_MAX_NODES,
   parameter int LOG_LEVELS = tlca_pkg::DEF_LOG_LEVELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tlca_pkg::NODE_W-1:0] csr_data,
   input  tlca_pkg::req_type           req_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output tlca_pkg::rsp_type           rsp_data,
   input  tlca_pkg::cmd_type           cmd,
   output tlca_pkg::sts_type           sts
);
   import tlca_pkg::*;

   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int LVL_W     = $clog2(LOG_LEVELS);
   localparam int MSB_W     = $clog2(DEPTH_W);
   localparam int FIELD_MAX = (1 << NODE_W) - 1;
   localparam int CLAMP     = (MAX_NODES - 1 > FIELD_MAX) ? FIELD_MAX : MAX_NODES - 1;

   logic [NODE_W-1:0]  anc_mem [LOG_LEVELS][MAX_NODES];
   logic [DEPTH_W-1:0] dep_mem [MAX_NODES];

   req_type            item_ff;
   logic [NODE_W-1:0]  node_count_ff;
   logic [IDX_W-1:0]   a_ff, a_in;
   logic [IDX_W-1:0]   b_ff, b_in;
   logic [DEPTH_W-1:0] da_ff;
   logic [DEPTH_W-1:0] diff_ff, diff_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [NODE_W-1:0]  res_anc_ff, res_anc_in;
   logic               res_done_ff, res_done_in;
   logic               res_err_ff, res_err_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [NODE_W-1:0]  rda_q_ff, rdb_q_ff;
   logic [DEPTH_W-1:0] dep_q_ff;

   logic [NODE_W-1:0]  active_cnt;
   logic [IDX_W-1:0]   active_idx;
   logic [IDX_W-1:0]   node_idx, other_idx;
   logic               node_ok, other_ok;
   logic [LVL_W-1:0]   lvl_dn;
   logic [LVL_W-1:0]   lift_lvl;
   logic [DEPTH_W-1:0] lift_step;
   logic [MSB_W-1:0]   msb;

   logic               anc_we;
   logic [LVL_W-1:0]   wr_lvl;
   logic [IDX_W-1:0]   wr_idx;
   logic [NODE_W-1:0]  wr_data;
   logic               rda_en, rdb_en, dep_en;
   logic [LVL_W-1:0]   rda_lvl, rdb_lvl;
   logic [IDX_W-1:0]   rda_idx, rdb_idx, dep_ra;

   // ---- range checks ----
   assign active_cnt = (node_count_ff > NODE_W'(CLAMP)) ? NODE_W'(CLAMP) : node_count_ff;
   assign active_idx = IDX_W'(active_cnt);
   assign node_idx   = IDX_W'(item_ff.node);
   assign other_idx  = IDX_W'(item_ff.other_node);
   assign node_ok    = (item_ff.node != '0) && (item_ff.node <= active_cnt);
   assign other_ok   = (item_ff.other_node != '0) && (item_ff.other_node <= active_cnt);
   assign lvl_dn     = LVL_W'(lvl_ff - 1'b1);

   // lift by the highest set bit of the remaining difference, capped at the top row
   always_comb begin
      msb = '0;
      for (int k = 0; k < DEPTH_W; k++) begin
         if (diff_ff[k]) msb = MSB_W'(k);
      end
      if (int'(msb) > LOG_LEVELS - 1) begin
         lift_lvl = LVL_W'(LOG_LEVELS - 1);
      end else begin
         lift_lvl = LVL_W'(msb);
      end
      lift_step = DEPTH_W'(1) << lift_lvl;
   end

   // ---- memory port selection ----
   always_comb begin
      anc_we  = cmd.tbl_wr | cmd.bld_init | cmd.bld_wr;
      wr_lvl  = '0;
      wr_idx  = '0;
      wr_data = '0;
      if (cmd.tbl_wr) begin
         wr_idx  = node_idx;
         wr_data = item_ff.parent;
      end else if (cmd.bld_wr) begin
         wr_lvl  = lvl_ff;
         wr_idx  = j_ff;
         wr_data = rda_q_ff;
      end

      rda_en  = cmd.bld_rd0 | cmd.bld_rd1 | cmd.jump_rd | cmd.fin_rd;
      rda_lvl = '0;
      rda_idx = a_ff;
      if (cmd.bld_rd0) begin
         rda_lvl = lvl_dn;
         rda_idx = j_ff;
      end else if (cmd.bld_rd1) begin
         rda_lvl = lvl_dn;
         rda_idx = IDX_W'(rda_q_ff);
      end else if (cmd.jump_rd) begin
         rda_lvl = lvl_ff;
      end

      rdb_en  = cmd.lift_rd | cmd.jump_rd;
      rdb_lvl = cmd.lift_rd ? lift_lvl : lvl_ff;
      rdb_idx = b_ff;

      dep_en = cmd.rd_depth_a | cmd.rd_depth_b;
      dep_ra = cmd.rd_depth_a ? node_idx : other_idx;
   end

   always_ff @(posedge clock) begin
      if (anc_we) anc_mem[wr_lvl][wr_idx] <= wr_data;
      if (rda_en) rda_q_ff <= anc_mem[rda_lvl][rda_idx];
      if (rdb_en) rdb_q_ff <= anc_mem[rdb_lvl][rdb_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr) dep_mem[node_idx] <= item_ff.depth;
      if (dep_en) dep_q_ff <= dep_mem[dep_ra];
   end

   // ---- walk registers ----
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      diff_in = diff_ff;
      lvl_in  = lvl_ff;
      j_in    = j_ff;
      if (cmd.bld_init) begin
         lvl_in = LVL_W'(1);
         j_in   = '0;
      end else if (cmd.bld_wr) begin
         if (j_ff == active_idx) begin
            j_in   = '0;
            lvl_in = LVL_W'(lvl_ff + 1'b1);
         end else begin
            j_in = IDX_W'(j_ff + 1'b1);
         end
      end
      if (cmd.rd_depth_a) begin
         a_in = node_idx;
         b_in = other_idx;
      end
      if (cmd.q_diff) begin
         // keep b as the deeper node
         if (da_ff > dep_q_ff) begin
            a_in    = b_ff;
            b_in    = a_ff;
            diff_in = da_ff - dep_q_ff;
         end else begin
            diff_in = dep_q_ff - da_ff;
         end
      end
      if (cmd.lift_rd) diff_in = diff_ff - lift_step;
      if (cmd.lift_up) b_in = IDX_W'(rdb_q_ff);
      if (cmd.jump_init) lvl_in = LVL_W'(LOG_LEVELS - 1);
      if (cmd.jump_up) begin
         if (rda_q_ff != rdb_q_ff) begin
            a_in = IDX_W'(rda_q_ff);
            b_in = IDX_W'(rdb_q_ff);
         end
         lvl_in = lvl_dn;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      diff_ff <= diff_in;
      lvl_ff  <= lvl_in;
      j_ff    <= j_in;
      if (cmd.rd_depth_b) da_ff <= dep_q_ff;
      if (cmd.item_load) item_ff <= req_data;
   end

   // ---- result ----
   always_comb begin
      res_anc_in  = res_anc_ff;
      res_done_in = res_done_ff;
      res_err_in  = res_err_ff;
      if (cmd.res_clear) begin
         res_anc_in  = '0;
         res_done_in = 1'b0;
         res_err_in  = 1'b0;
      end
      if (cmd.res_err) res_err_in = 1'b1;
      if (cmd.res_done) res_done_in = 1'b1;
      if (cmd.meet_res) begin
         res_anc_in  = NODE_W'(b_ff);
         res_done_in = 1'b1;
      end
      if (cmd.fin_up) begin
         res_anc_in  = rda_q_ff;
         res_done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_anc_ff  <= res_anc_in;
      res_done_ff <= res_done_in;
      res_err_ff  <= res_err_in;
      if (cmd.rsp_load) begin
         rsp_data_ff.ancestor <= res_anc_ff;
         rsp_data_ff.done_res <= res_done_ff;
         rsp_data_ff.error    <= res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= NODE_W'(1);
      end else begin
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) node_count_ff <= csr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- status ----
   always_comb begin
      sts.kind      = item_ff.kind;
      sts.load_ok   = node_ok && (item_ff.parent <= active_cnt);
      sts.query_ok  = node_ok && other_ok;
      sts.bld_last  = (lvl_ff == LVL_W'(LOG_LEVELS - 1)) && (j_ff == active_idx);
      sts.diff_zero = (diff_ff == '0);
      sts.ab_equal  = (a_ff == b_ff);
      sts.jump_last = (lvl_ff == '0);
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid_ff || rsp_ready)
      else $error("pending result overwritten");

   a_build_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.bld_wr |-> (lvl_ff != '0) && (j_ff <= active_idx))
      else $error("build write outside its row range");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && res_err_ff |-> !res_done_ff && (res_anc_ff == '0))
      else $error("error result carries done or an ancestor");

   a_lift_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.lift_rd |=> diff_ff < $past(diff_ff))
      else $error("lift step did not reduce the depth difference");

endmodule

FILE: rtl/tree_lca_binary_lifting.sv
// Lowest-common-ancestor engine over a rooted tree, by binary lifting.
// Channels: req (load, build or query item), rsp (one result per item), each
// valid/ready; csr writes node_count and is always ready.
// Load writes the parent and depth of one node. Build: per table entry, its two
// dependent ancestor-memory reads and then the write. Query: J lift jumps, J the
// number of set bits of the depth difference (more when it passes the top row),
// each a read and an update on the registered two-port ancestor memory; when the
// lifted node does not already meet the other, a jump walk down all LOG_LEVELS
// rows and a final parent read follow. Invalid items and unknown kinds go
// straight to the result.
// One item is worked at a time; after each result the sequencer returns to idle
// before it takes the next item.
// One result may wait in the rsp register while the next item runs.
// A stalled rsp holds the finished item in its last state until transfer.
// Reset sets node_count to 1 and idles the sequencer; the tables are not
// cleared and hold nothing usable until nodes are loaded and a build is run.
// Write csr only while idle.
module tree_lca_binary_lifting #(
   parameter int MAX_NODES  = tlca_pkg::DEF_MAX_NODES,
   parameter int LOG_LEVELS = tlca_pkg::DEF_LOG_LEVELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tlca_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tlca_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tlca_pkg::NODE_W-1:0] csr_data
);
   import tlca_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   tlca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlca_dpath #(
      .MAX_NODES  (MAX_NODES),
      .LOG_LEVELS (LOG_LEVELS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for tree_lca_binary_lifting: parent/depth loads, ancestor table
// builds and LCA queries, each result checked against an in-bench binary-lifting model.
// Depends on tlca_pkg and the tree_lca_binary_lifting RTL.
module tb_top;
   import tlca_pkg::*;

   localparam int LEVELS = DEF_LOG_LEVELS;
   localparam int NODES = DEF_MAX_NODES;
   localparam int MAX_ID = NODES - 1;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1250;
   localparam int STALL_CYCLES = 300;
   localparam int CHAIN_NODES = 600;
   localparam int CHAIN_DEPTH = 530;

   typedef logic [NODE_W-1:0] node_id_type;
   typedef enum {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   node_id_type csr_data = '0;

   // Model state: jump table row i holds each node's 2^i-th ancestor.
   bit [NODE_W-1:0]  jump_tbl [LEVELS][NODES];
   bit [DEPTH_W-1:0] depth_tbl [NODES];
   node_id_type      node_limit = 1;
   rsp_type          lca_results_due [$];

   pace_mode_type pace = PACE_RX_SLOW;
   int            rx_hold_cycles = 0;
   int            fail_count = 0;
   int            cycle_count = 0;
   int            items_sent = 0;

   tree_lca_binary_lifting u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic int sender_idle_pct();
      case (pace)
         PACE_RX_SLOW: return 27;
         PACE_TX_SLOW: return 69;
         default:      return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (pace)
         PACE_RX_SLOW: return 69;
         PACE_TX_SLOW: return 27;
         default:      return 0;
      endcase
   endfunction

   function automatic bit in_tree(node_id_type n);
      return n != 0 && n <= node_limit;
   endfunction

   function automatic node_id_type lowest_common(node_id_type a, node_id_type b);
      node_id_type swap;
      node_id_type pa;
      node_id_type pb;
      int          gap;
      int          lvl;
      if (depth_tbl[a] > depth_tbl[b]) begin
         swap = a;
         a = b;
         b = swap;
      end
      gap = int'(depth_tbl[b]) - int'(depth_tbl[a]);
      // Lift the deeper node by the largest power of two left in the gap.
      while (gap > 0) begin
         lvl = 0;
         while (lvl + 1 < LEVELS && (gap >> (lvl + 1)) != 0) lvl++;
         b = jump_tbl[lvl][b];
         gap -= 1 << lvl;
      end
      if (a == b) return b;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         pa = jump_tbl[i][a];
         pb = jump_tbl[i][b];
         if (pa != pb) begin
            a = pa;
            b = pb;
         end
      end
      return jump_tbl[0][a];
   endfunction

   // Apply one item to the model and return the result it must produce.
   function automatic rsp_type lca_outcome(req_type item);
      rsp_type res;
      res = '0;
      case (item.kind)
         KIND_LOAD: begin
            if (!in_tree(item.node) || item.parent > node_limit) begin
               res.error = 1'b1;
            end else begin
               jump_tbl[0][item.node] = item.parent;
               depth_tbl[item.node] = item.depth;
               res.done_res = 1'b1;
            end
         end
         KIND_BUILD: begin
            jump_tbl[0][0] = '0;
            for (int i = 1; i < LEVELS; i++) begin
               for (int j = 0; j <= node_limit; j++) begin
                  jump_tbl[i][j] = jump_tbl[i-1][jump_tbl[i-1][j]];
               end
            end
            res.done_res = 1'b1;
         end
         KIND_QUERY: begin
            if (!in_tree(item.node) || !in_tree(item.other_node)) begin
               res.error = 1'b1;
            end else begin
               res.ancestor = lowest_common(item.node, item.other_node);
               res.done_res = 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input node_id_type want,
                              input node_id_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lca_results_due.size() == 0) begin
            $error("result transfer with nothing pending: %p", rsp_data);
            fail_count++;
         end else begin
            due = lca_results_due.pop_front();
            check_field("ancestor", due.ancestor, rsp_data.ancestor);
            check_field("done_res", node_id_type'(due.done_res),
                        node_id_type'(rsp_data.done_res));
            check_field("error", node_id_type'(due.error), node_id_type'(rsp_data.error));
         end
      end
   end

   // Result side: random back-pressure, or a long hold when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
         end
      end
   end

   function automatic req_type random_fields();
      req_type r;
      r.kind = KIND_W'($urandom_range(0, 3));
      r.node = NODE_W'($urandom_range(0, MAX_ID));
      r.parent = NODE_W'($urandom_range(0, MAX_ID));
      r.depth = DEPTH_W'($urandom_range(0, MAX_ID));
      r.other_node = NODE_W'($urandom_range(0, MAX_ID));
      return r;
   endfunction

   function automatic req_type load_item(node_id_type node, node_id_type parent,
                                         logic [DEPTH_W-1:0] depth);
      req_type r;
      r = random_fields();
      r.kind = KIND_LOAD;
      r.node = node;
      r.parent = parent;
      r.depth = depth;
      return r;
   endfunction

   function automatic req_type build_item();
      req_type r;
      r = random_fields();
      r.kind = KIND_BUILD;
      return r;
   endfunction

   function automatic req_type query_item(node_id_type a, node_id_type b);
      req_type r;
      r = random_fields();
      r.kind = KIND_QUERY;
      r.node = a;
      r.other_node = b;
      return r;
   endfunction

   function automatic req_type stray_item();
      req_type r;
      r = random_fields();
      r.kind = KIND_UNUSED;
      return r;
   endfunction

   // Rejected loads and queries and unused kinds; none of them reads the tables.
   function automatic req_type noise_item();
      req_type     r;
      node_id_type outside;
      r = random_fields();
      outside = '0;
      if (node_limit < MAX_ID && $urandom_range(0, 1) == 1)
         outside = node_id_type'($urandom_range(node_limit + 1, MAX_ID));
      case ($urandom_range(0, 3))
         0: begin
            r.kind = KIND_LOAD;
            r.node = outside;
         end
         1: begin
            r.kind = KIND_LOAD;
            r.node = node_id_type'($urandom_range(1, node_limit));
            if (node_limit < MAX_ID)
               r.parent = node_id_type'($urandom_range(node_limit + 1, MAX_ID));
            else r.node = '0;
         end
         2: begin
            r.kind = KIND_QUERY;
            if ($urandom_range(0, 1) == 1) r.node = outside;
            else r.other_node = outside;
         end
         default: r.kind = KIND_UNUSED;
      endcase
      return r;
   endfunction

   task automatic send_item(input req_type item);
      rsp_type outcome;
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      outcome = lca_outcome(item);
      lca_results_due = {lca_results_due, outcome};
      if (item.kind != KIND_UNUSED) items_sent++;
   endtask

   // Hold the sender until every pending result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (lca_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input node_id_type value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      node_limit = value;
   endtask

   // Load a tree of count nodes, build it, query it amid noise, reloads and rebuilds.
   task automatic grow_tree(input int count, input bit deep_chain);
      int unsigned level [NODES];
      int          span;
      int          queries;
      int unsigned depth;
      node_id_type parent;
      node_id_type a;
      node_id_type b;
      drain_results();
      write_node_count(node_id_type'(count));
      span = deep_chain ? 1 : $urandom_range(1, 8);
      for (int k = 1; k <= count; k++) begin
         if (k == 1 || (!deep_chain && $urandom_range(0, 11) == 0))
            parent = '0;
         else if (deep_chain && k > CHAIN_DEPTH)
            parent = node_id_type'($urandom_range(1, k - 1));
         else
            parent = node_id_type'($urandom_range(k > span ? k - span : 1, k - 1));
         depth = (parent == 0) ? 0 : (level[parent] + 1) % NODES;
         if (!deep_chain && $urandom_range(0, 9) == 0) depth = $urandom_range(0, MAX_ID);
         level[k] = depth;
         send_item(load_item(node_id_type'(k), parent, DEPTH_W'(depth)));
         if ($urandom_range(0, deep_chain ? 39 : 9) == 0) send_item(noise_item());
      end
      send_item(build_item());
      queries = deep_chain ? 40 : $urandom_range(8, 30);
      repeat (queries) begin
         case ($urandom_range(0, 19))
            0: send_item(noise_item());
            // Reshape one node; upper rows stay stale until the next build.
            1: send_item(load_item(node_id_type'($urandom_range(1, count)),
                                   node_id_type'($urandom_range(0, count)),
                                   DEPTH_W'($urandom_range(0, MAX_ID))));
            2: send_item(build_item());
            default: begin
               a = node_id_type'($urandom_range(1, count));
               b = ($urandom_range(0, 3) == 0) ? a : node_id_type'($urandom_range(1, count));
               send_item(query_item(a, b));
            end
         endcase
      end
   endtask

   // Largest node count: an edge load, random loads and noise items, nothing built.
   task automatic probe_full_range();
      drain_results();
      write_node_count(node_id_type'(MAX_ID));
      send_item(load_item(node_id_type'(MAX_ID), node_id_type'(MAX_ID), DEPTH_W'(MAX_ID)));
      repeat (24) begin
         if ($urandom_range(0, 2) == 0)
            send_item(load_item(node_id_type'($urandom_range(1, MAX_ID)),
                                node_id_type'($urandom_range(0, MAX_ID)),
                                DEPTH_W'($urandom_range(0, MAX_ID))));
         else
            send_item(noise_item());
      end
   endtask

   task automatic test_reset_defaults();
      req_type all_ones;
      all_ones = '1;
      send_item(all_ones);
      send_item(query_item(1, 0));
      send_item(query_item(node_id_type'(MAX_ID), 1));
      send_item(load_item(0, 0, 0));
      send_item(load_item(1, 2, 0));
      send_item(load_item(node_id_type'(MAX_ID), node_id_type'(MAX_ID), 5));
      send_item(load_item(1, 0, 0));
      send_item(build_item());
      send_item(query_item(1, 1));
   endtask

   task automatic test_small_tree();
      drain_results();
      write_node_count(7);
      send_item(load_item(1, 0, 0));
      send_item(load_item(2, 1, 1));
      send_item(load_item(3, 1, 1));
      send_item(load_item(4, 2, 2));
      send_item(load_item(5, 4, 3));
      send_item(load_item(6, 0, 0));
      // Depth far beyond its real chain: lifting runs past the root to node 0.
      send_item(load_item(7, 6, DEPTH_W'(MAX_ID)));
      send_item(build_item());
      send_item(query_item(5, 3));
      send_item(query_item(4, 5));
      send_item(query_item(5, 5));
      send_item(query_item(7, 6));
      send_item(query_item(3, 7));
      send_item(query_item(1, 8));
   endtask

   task automatic test_result_stall();
      rx_hold_cycles = STALL_CYCLES;
      repeat (10) send_item(query_item(node_id_type'($urandom_range(1, 7)),
                                       node_id_type'($urandom_range(1, 7))));
      drain_results();
   endtask

   task automatic test_random_trees();
      int session;
      int first;
      int sent_so_far;
      session = 0;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         sent_so_far = items_sent - first;
         if (sent_so_far < RANDOM_ITEMS / 3) pace = PACE_RX_SLOW;
         else if (sent_so_far < 2 * RANDOM_ITEMS / 3) pace = PACE_TX_SLOW;
         else pace = PACE_FULL;
         session++;
         if (session == 3) grow_tree(CHAIN_NODES, 1'b1);
         else if (session == 6) probe_full_range();
         else grow_tree(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 48), 1'b0);
         if ($urandom_range(0, 3) == 0) send_item(stray_item());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_small_tree();
      test_result_stall();
      test_random_trees();
      drain_results();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
rtl/tlca_pkg.sv
rtl/tlca_ctrl.sv
rtl/tlca_dpath.sv
rtl/tree_lca_binary_lifting.sv
verif/tb_top.sv
